FILE: hdl/radix_n_morton_codec_defines.svh
// ----------------------------------------------------------------------------
// radix_n_morton_codec assertion macros
// shared property wrappers for the codec's checker
// ----------------------------------------------------------------------------
`ifndef RADIX_N_MORTON_CODEC_DEFINES_SVH
`define RADIX_N_MORTON_CODEC_DEFINES_SVH

// property sampled on clk, switched off while rst is high
`define RNMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// property sampled on clk, also checked during reset
`define RNMC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/rnmc_pkg.sv
// ----------------------------------------------------------------------------
// rnmc_pkg
// shared constants and control types of the general-radix morton codec
// ----------------------------------------------------------------------------
`default_nettype none

package rnmc_pkg;

  localparam int COORD_BITS     = 20;
  localparam int RADIX_BITS     = 8;
  localparam int LEVEL_BITS     = 4;
  localparam int CFG_ADDR_BITS  = 1;
  localparam int MAX_LEVELS_DEF = 10;
  localparam int INDEX_BITS_DEF = 31;

  localparam logic [COORD_BITS-1:0] COORD_MAX  = '1;
  localparam logic [RADIX_BITS-1:0] RADIX_MIN  = 8'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_RST  = 8'd2;
  localparam logic [LEVEL_BITS-1:0] LEVELS_RST = 4'd1;

  // register indexes
  localparam logic [CFG_ADDR_BITS-1:0] CFG_RADIX  = 1'b0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_LEVELS = 1'b1;

  // operation codes
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // digit slots within one round: y, x, z
  localparam logic [1:0] SLOT_Y = 2'd0;
  localparam logic [1:0] SLOT_X = 2'd1;
  localparam logic [1:0] SLOT_Z = 2'd2;

  typedef struct packed {
    logic       clear;
    logic       decode;
    logic       mul_en;
    logic       add_en;
    logic       w_bump;
    logic [1:0] slot;
  } wacc_ctl_t;

  typedef struct packed {
    logic valid;
    logic decode;
    logic rest_nz;
  } seq_res_t;

endpackage

`default_nettype wire

FILE: hdl/rnmc_div_unit.sv
// ----------------------------------------------------------------------------
// rnmc_div_unit
// shared divide-by-radix unit, eight quotient bits per cycle, msb first
// ----------------------------------------------------------------------------
`default_nettype none

module rnmc_div_unit #(
  parameter int DIV_W = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [DIV_W-1:0]                dividend,
  input  logic [rnmc_pkg::RADIX_BITS-1:0] radix,
  output logic                            done,
  output logic [DIV_W-1:0]                quot,
  output logic [rnmc_pkg::RADIX_BITS-1:0] digit
);
  import rnmc_pkg::*;

  localparam int NCHUNK = (DIV_W + 7) / 8;
  localparam int CH_W   = NCHUNK * 8;
  localparam int CNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  logic [CH_W-1:0]       sh;
  logic [RADIX_BITS-1:0] rem;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic [RADIX_BITS-1:0] rem_next;
  logic [7:0]            qbits;

  // eight restoring steps on the top byte of the shift word
  always_comb begin
    logic [RADIX_BITS:0]   t;
    logic [RADIX_BITS-1:0] rm;
    rm    = rem;
    qbits = '0;
    for (int j = 0; j < 8; j++) begin
      t = {rm, sh[CH_W-1-j]};
      if (t >= {1'b0, radix}) begin
        qbits[7-j] = 1'b1;
        rm         = RADIX_BITS'(t - {1'b0, radix});
      end else begin
        qbits[7-j] = 1'b0;
        rm         = t[RADIX_BITS-1:0];
      end
    end
    rem_next = rm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(NCHUNK - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        sh   <= CH_W'(dividend);
        rem  <= '0;
      end else if (busy) begin
        sh  <= {sh[CH_W-9:0], qbits};
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NCHUNK - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quot  = sh[DIV_W-1:0];
  assign digit = rem;

endmodule

`default_nettype wire

FILE: hdl/rnmc_wacc.sv
// ----------------------------------------------------------------------------
// rnmc_wacc
// weighted digit accumulator with saturation and running radix weight
// ----------------------------------------------------------------------------
`default_nettype none

module rnmc_wacc #(
  parameter int INDEX_BITS = rnmc_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rnmc_pkg::wacc_ctl_t             ctl,
  input  logic [rnmc_pkg::RADIX_BITS-1:0] digit,
  input  logic [rnmc_pkg::RADIX_BITS-1:0] radix,
  output logic [((INDEX_BITS > rnmc_pkg::COORD_BITS) ? INDEX_BITS
                 : rnmc_pkg::COORD_BITS)-1:0] acc_y,
  output logic [((INDEX_BITS > rnmc_pkg::COORD_BITS) ? INDEX_BITS
                 : rnmc_pkg::COORD_BITS)-1:0] acc_x,
  output logic [((INDEX_BITS > rnmc_pkg::COORD_BITS) ? INDEX_BITS
                 : rnmc_pkg::COORD_BITS)-1:0] acc_z,
  output logic                            ovf
);
  import rnmc_pkg::*;

  localparam int ACC_W = (INDEX_BITS > COORD_BITS) ? INDEX_BITS : COORD_BITS;
  localparam int W_W   = ACC_W + 1;
  localparam int PW    = W_W + RADIX_BITS;
  localparam logic [ACC_W-1:0] INDEX_CAP = ACC_W'({INDEX_BITS{1'b1}});
  localparam logic [ACC_W-1:0] COORD_CAP = ACC_W'(COORD_MAX);

  logic [ACC_W-1:0] acc [3];
  logic [ACC_W-1:0] cap;
  logic [W_W-1:0]   w;
  logic [PW-1:0]    prod_q;
  logic [PW-1:0]    wr_q;
  logic [PW:0]      sum;
  logic             sum_over;
  logic [W_W-1:0]   w_next;

  always_comb begin
    sum      = (PW+1)'(acc[ctl.slot]) + (PW+1)'(prod_q);
    sum_over = sum > (PW+1)'(cap);
    w_next   = (wr_q > PW'(cap)) ? (W_W'(cap) + W_W'(1)) : wr_q[W_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf <= 1'b0;
    end else if (ctl.clear) begin
      ovf <= 1'b0;
    end else if (ctl.add_en && sum_over) begin
      ovf <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      for (int i = 0; i < 3; i++) begin
        acc[i] <= '0;
      end
      w   <= W_W'(1);
      cap <= ctl.decode ? COORD_CAP : INDEX_CAP;
    end else begin
      if (ctl.mul_en) begin
        prod_q <= PW'(digit) * PW'(w);
        wr_q   <= PW'(w) * PW'(radix);
      end
      if (ctl.add_en) begin
        acc[ctl.slot] <= sum_over ? cap : sum[ACC_W-1:0];
        if (ctl.w_bump) begin
          w <= w_next;
        end
      end
    end
  end

  assign acc_y = acc[SLOT_Y];
  assign acc_x = acc[SLOT_X];
  assign acc_z = acc[SLOT_Z];

endmodule

`default_nettype wire

FILE: hdl/rnmc_seq.sv
// ----------------------------------------------------------------------------
// rnmc_seq
// digit sequencer: operand registers, round counters and unit control
// ----------------------------------------------------------------------------
`default_nettype none

module rnmc_seq #(
  parameter int MAX_LEVELS = rnmc_pkg::MAX_LEVELS_DEF,
  parameter int INDEX_BITS = rnmc_pkg::INDEX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              ready,
  input  logic                              in_op,
  input  logic [rnmc_pkg::COORD_BITS-1:0]   in_x,
  input  logic [rnmc_pkg::COORD_BITS-1:0]   in_y,
  input  logic [rnmc_pkg::COORD_BITS-1:0]   in_z,
  input  logic [INDEX_BITS-1:0]             in_index,
  input  logic [$clog2(MAX_LEVELS+1)-1:0]   lv,
  output logic                              div_start,
  output logic [((INDEX_BITS > rnmc_pkg::COORD_BITS) ? INDEX_BITS
                 : rnmc_pkg::COORD_BITS)-1:0] div_dividend,
  input  logic                              div_done,
  input  logic [((INDEX_BITS > rnmc_pkg::COORD_BITS) ? INDEX_BITS
                 : rnmc_pkg::COORD_BITS)-1:0] div_quot,
  output rnmc_pkg::wacc_ctl_t               ctl,
  input  logic                              out_free,
  output rnmc_pkg::seq_res_t                res
);
  import rnmc_pkg::*;

  localparam int DIV_W = (INDEX_BITS > COORD_BITS) ? INDEX_BITS : COORD_BITS;
  localparam int LV_W  = $clog2(MAX_LEVELS + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_ADD   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                state;
  state_t                state_next;
  logic                  dec;
  logic [COORD_BITS-1:0] val [3];
  logic [INDEX_BITS-1:0] n;
  logic [1:0]            k;
  logic [LV_W-1:0]       lvl;
  logic                  accept;
  logic                  more;

  always_comb begin
    ready  = (state == ST_IDLE);
    accept = in_valid && ready;
    if (dec) begin
      more = (lvl < LV_W'(MAX_LEVELS)) && (n != '0);
    end else begin
      more = (lvl < lv);
    end
    div_start    = (state == ST_CHECK) && more;
    div_dividend = dec ? DIV_W'(n) : DIV_W'(val[k]);

    ctl.clear  = accept;
    ctl.decode = accept ? (in_op == OP_DECODE) : dec;
    ctl.mul_en = (state == ST_MUL);
    ctl.add_en = (state == ST_ADD);
    ctl.w_bump = !dec || (k == SLOT_Z);
    ctl.slot   = dec ? k : SLOT_Y;

    res.valid   = (state == ST_DONE);
    res.decode  = dec;
    res.rest_nz = dec && (n != '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_CHECK;
      ST_CHECK: state_next = more ? ST_DIV : ST_DONE;
      ST_DIV:   if (div_done) state_next = ST_MUL;
      ST_MUL:   state_next = ST_ADD;
      ST_ADD:   state_next = ST_CHECK;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dec         <= (in_op == OP_DECODE);
      val[SLOT_Y] <= in_y;
      val[SLOT_X] <= in_x;
      val[SLOT_Z] <= in_z;
      n           <= in_index;
      k           <= SLOT_Y;
      lvl         <= '0;
    end else begin
      if ((state == ST_DIV) && div_done) begin
        if (dec) begin
          n <= div_quot[INDEX_BITS-1:0];
        end else begin
          val[k] <= div_quot[COORD_BITS-1:0];
        end
      end
      if (state == ST_ADD) begin
        if (k == SLOT_Z) begin
          k   <= SLOT_Y;
          lvl <= lvl + 1'b1;
        end else begin
          k <= k + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/radix_n_morton_codec.sv
// ----------------------------------------------------------------------------
// radix_n_morton_codec
// 3d coordinate <-> morton index conversion in a configurable radix
// D = digits worked per item: 3*num_levels for encode (num_levels capped at
//   MAX_LEVELS); up to 3*MAX_LEVELS for decode, fewer once the index runs out
// each digit goes through the shared divider, then a multiply and an add step
// one item at a time: s_tready stays low until the result goes to the output register
// reset: synchronous; radix 2, num_levels 1, no result pending
// ----------------------------------------------------------------------------
`default_nettype none

module radix_n_morton_codec #(
  parameter int MAX_LEVELS = rnmc_pkg::MAX_LEVELS_DEF,
  parameter int INDEX_BITS = rnmc_pkg::INDEX_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [rnmc_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
  input  logic [rnmc_pkg::RADIX_BITS-1:0]       cfg_wr_data,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // coord_x, coord_y, coord_z, index_in, zero pad
  input  logic [((3*rnmc_pkg::COORD_BITS+INDEX_BITS+7)/8)*8-1:0] s_tdata,
  // operation
  input  logic [0:0]                            s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // index_out, x_out, y_out, z_out, zero pad
  output logic [((3*rnmc_pkg::COORD_BITS+INDEX_BITS+7)/8)*8-1:0] m_tdata,
  // overflow
  output logic [0:0]                            m_tuser
);
  import rnmc_pkg::*;

  localparam int DATA_W = ((3*COORD_BITS + INDEX_BITS + 7) / 8) * 8;
  localparam int ACC_W  = (INDEX_BITS > COORD_BITS) ? INDEX_BITS : COORD_BITS;
  localparam int LV_W   = $clog2(MAX_LEVELS + 1);

  logic [RADIX_BITS-1:0] radix;
  logic [LEVEL_BITS-1:0] num_levels;
  logic [RADIX_BITS-1:0] r_eff;
  logic [LV_W-1:0]       lv_eff;

  logic                  div_start;
  logic [ACC_W-1:0]      div_dividend;
  logic                  div_done;
  logic [ACC_W-1:0]      div_quot;
  logic [RADIX_BITS-1:0] digit;
  wacc_ctl_t             ctl;
  seq_res_t              res;
  logic [ACC_W-1:0]      acc_y;
  logic [ACC_W-1:0]      acc_x;
  logic [ACC_W-1:0]      acc_z;
  logic                  acc_ovf;
  logic                  out_free;
  logic [DATA_W-1:0]     out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix      <= RADIX_RST;
      num_levels <= LEVELS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_RADIX:  radix      <= cfg_wr_data;
        CFG_LEVELS: num_levels <= cfg_wr_data[LEVEL_BITS-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    r_eff  = (radix < RADIX_MIN) ? RADIX_MIN : radix;
    lv_eff = (32'(num_levels) > MAX_LEVELS) ? LV_W'(MAX_LEVELS) : LV_W'(num_levels);
  end

  rnmc_seq #(
    .MAX_LEVELS (MAX_LEVELS),
    .INDEX_BITS (INDEX_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .ready        (s_tready),
    .in_op        (s_tuser[0]),
    .in_x         (s_tdata[COORD_BITS-1:0]),
    .in_y         (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_z         (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .in_index     (s_tdata[3*COORD_BITS +: INDEX_BITS]),
    .lv           (lv_eff),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_done     (div_done),
    .div_quot     (div_quot),
    .ctl          (ctl),
    .out_free     (out_free),
    .res          (res)
  );

  rnmc_div_unit #(
    .DIV_W (ACC_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .radix    (r_eff),
    .done     (div_done),
    .quot     (div_quot),
    .digit    (digit)
  );

  rnmc_wacc #(
    .INDEX_BITS (INDEX_BITS)
  ) u_wacc (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .digit (digit),
    .radix (r_eff),
    .acc_y (acc_y),
    .acc_x (acc_x),
    .acc_z (acc_z),
    .ovf   (acc_ovf)
  );

  // output register, frees the core while a result waits
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    out_word = '0;
    if (res.decode) begin
      out_word[INDEX_BITS +: COORD_BITS]                = acc_x[COORD_BITS-1:0];
      out_word[INDEX_BITS + COORD_BITS +: COORD_BITS]   = acc_y[COORD_BITS-1:0];
      out_word[INDEX_BITS + 2*COORD_BITS +: COORD_BITS] = acc_z[COORD_BITS-1:0];
    end else begin
      out_word[INDEX_BITS-1:0] = acc_y[INDEX_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && out_free) begin
      m_tdata    <= out_word;
      m_tuser[0] <= acc_ovf || res.rest_nz;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rnmc_checker.sv
// ----------------------------------------------------------------------------
// rnmc_checker
// port-level checks of the morton codec, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "radix_n_morton_codec_defines.svh"

module rnmc_checker #(
  parameter int INDEX_BITS = rnmc_pkg::INDEX_BITS_DEF
) (
  input logic                                                  clk,
  input logic                                                  rst,
  input logic                                                  s_tvalid,
  input logic                                                  s_tready,
  input logic                                                  m_tvalid,
  input logic                                                  m_tready,
  input logic [((3*rnmc_pkg::COORD_BITS+INDEX_BITS+7)/8)*8-1:0] m_tdata
);
  import rnmc_pkg::*;

  // reset empties the output register
  `RNMC_ASSERT_RST(a_rst_empty, rst |=> !m_tvalid, "result valid after reset")

  // one item at a time: taking an item closes the input
  `RNMC_ASSERT(a_busy_after_take, s_tvalid && s_tready |=> !s_tready, "ready while busy")

  // a result carries either an index or coordinates, never both
  `RNMC_ASSERT(a_one_side_zero, m_tvalid |-> (m_tdata[INDEX_BITS-1:0] == '0) || (m_tdata[INDEX_BITS +: 3*COORD_BITS] == '0), "index and coordinates both set")

  // a stalled result holds
  `RNMC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind radix_n_morton_codec rnmc_checker #(
  .INDEX_BITS (INDEX_BITS)
) u_rnmc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
